// ----- sv/irpc_pkg.sv -----
// shared types and constants for the ir pulse period capture block
`default_nettype none

package irpc_pkg;

    localparam int unsigned CountW     = 8;
    localparam int unsigned ValueW     = 8;
    localparam int unsigned CfgW       = 8;
    localparam int unsigned CfgIndexW  = 1;
    localparam int unsigned BufferSlotsDefault = 64;

    localparam logic [CountW-1:0] FirstSlot      = CountW'(2);
    localparam logic [CountW-1:0] CountMax       = '1;
    localparam logic [CfgW-1:0]   StartThreshRst = CfgW'(20);
    localparam logic [CfgW-1:0]   StopThreshRst  = CfgW'(100);

    typedef enum logic [CfgIndexW-1:0] {
        CFG_START_THRESHOLD = 1'b0,
        CFG_STOP_THRESHOLD  = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_PERIOD    = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    typedef struct packed {
        logic              receiving;
        logic [CountW-1:0] tick_count;
        logic              previous_level;
        logic              await_sync;
        logic [CountW-1:0] slot_index;
    } t_state;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [ValueW-1:0] value;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/irpc_step.sv -----
// next-state and result logic for one pin sample
`default_nettype none

module irpc_step #(
    parameter int unsigned BUFFER_SLOTS = irpc_pkg::BufferSlotsDefault
) (
    input  wire logic                        i_level,
    input  wire irpc_pkg::t_state            i_state,
    input  wire logic [irpc_pkg::CfgW-1:0]   i_start_threshold,
    input  wire logic [irpc_pkg::CfgW-1:0]   i_stop_threshold,
    output irpc_pkg::t_state                 o_state,
    output irpc_pkg::t_result                o_result
);

    localparam logic [irpc_pkg::CountW:0] Slots = (irpc_pkg::CountW+1)'(BUFFER_SLOTS);

    logic [irpc_pkg::CountW-1:0] w_count_inc;
    logic [irpc_pkg::CountW:0]   w_slot_next;

    assign w_count_inc = (i_state.tick_count == irpc_pkg::CountMax) ?
                         i_state.tick_count : i_state.tick_count + 1'b1;
    assign w_slot_next = {1'b0, i_state.slot_index} + 1'b1;

    always_comb begin
        o_state  = i_state;
        o_result = '{valid: 1'b0, kind: irpc_pkg::KIND_PERIOD, value: '0};
        o_state.previous_level = i_level;
        if (!i_state.receiving) begin
            if (!i_level) begin
                o_state.tick_count = w_count_inc;
                if (w_count_inc >= i_start_threshold) begin
                    o_state.receiving  = 1'b1;
                    o_state.await_sync = 1'b1;
                    o_state.slot_index = irpc_pkg::FirstSlot;
                end
            end else begin
                o_state.tick_count = '0;
            end
        end else if (i_level == i_state.previous_level) begin
            if (!i_state.await_sync) begin
                o_state.tick_count = w_count_inc;
                if (w_count_inc >= i_stop_threshold) begin
                    o_state.receiving  = 1'b0;
                    o_state.tick_count = '0;
                    o_result = '{valid: 1'b1, kind: irpc_pkg::KIND_FRAME_END,
                                 value: i_state.slot_index};
                end
            end
        end else begin
            if (!i_state.await_sync) begin
                if (!i_state.previous_level) begin
                    if (w_slot_next < Slots) begin
                        o_result = '{valid: 1'b1, kind: irpc_pkg::KIND_PERIOD,
                                     value: i_state.tick_count >> 1};
                        o_state.slot_index = w_slot_next[irpc_pkg::CountW-1:0];
                    end
                    o_state.tick_count = irpc_pkg::CountW'(1);
                end else begin
                    o_state.tick_count = w_count_inc;
                end
            end
            o_state.await_sync = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/irpc_out_reg.sv -----
// output result register with stream handshake
`default_nettype none

module irpc_out_reg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire irpc_pkg::t_result           i_result,
    output logic                             o_free,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [irpc_pkg::ValueW-1:0]      o_m_tdata,
    output logic                             o_m_tuser
);

    logic                          r_valid;
    irpc_pkg::t_kind               r_kind;
    logic [irpc_pkg::ValueW-1:0]   r_value;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_result.valid) begin
            r_kind  <= i_result.kind;
            r_value <= i_result.value;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_value;
    assign o_m_tuser  = r_kind;

endmodule

`default_nettype wire

// ----- sv/ir_pulse_period_capture_core.sv -----
// top level of the ir pulse period capture block
// an accepted sample passes the input register and then the result register before its result appears
// throughput: one sample per cycle while the result side is ready; the sample register
// stalls only while a held result is not taken
// reset: synchronous active-low, clears control state, thresholds go to 20 and 100
`default_nettype none

module ir_pulse_period_capture_core #(
    parameter int unsigned BUFFER_SLOTS = irpc_pkg::BufferSlotsDefault
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [irpc_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  wire logic [irpc_pkg::CfgW-1:0]       i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [0] pin_level
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] value
    output logic                                 m_axis_tuser   // [0] kind
);

    logic [irpc_pkg::CfgW-1:0] r_start_threshold;
    logic [irpc_pkg::CfgW-1:0] r_stop_threshold;
    irpc_pkg::t_state          r_state;
    irpc_pkg::t_state          n_state;
    irpc_pkg::t_result         w_result;
    logic                      r_in_valid;
    logic                      r_in_level;
    logic                      w_out_free;
    logic                      w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_threshold <= irpc_pkg::StartThreshRst;
            r_stop_threshold  <= irpc_pkg::StopThreshRst;
        end else if (i_cfg_we) begin
            unique case (irpc_pkg::t_cfg_index'(i_cfg_index))
                irpc_pkg::CFG_START_THRESHOLD: r_start_threshold <= i_cfg_wdata;
                irpc_pkg::CFG_STOP_THRESHOLD:  r_stop_threshold  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    irpc_step #(
        .BUFFER_SLOTS(BUFFER_SLOTS)
    ) u_step (
        .i_level          (r_in_level),
        .i_state          (r_state),
        .i_start_threshold(r_start_threshold),
        .i_stop_threshold (r_stop_threshold),
        .o_state          (n_state),
        .o_result         (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{receiving: 1'b0, tick_count: '0, previous_level: 1'b0,
                         await_sync: 1'b0, slot_index: irpc_pkg::FirstSlot};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    irpc_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_advance),
        .i_result  (w_result),
        .o_free    (w_out_free),
        .o_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .o_m_tdata (m_axis_tdata),
        .o_m_tuser (m_axis_tuser)
    );

    a_sync_only_when_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.await_sync |-> r_state.receiving)
        else $error("sync armed outside receiving mode");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_state.slot_index) < BUFFER_SLOTS) && (r_state.slot_index >= irpc_pkg::FirstSlot))
        else $error("slot index out of range");

    a_frame_end_leaves_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_result.valid && w_result.kind == irpc_pkg::KIND_FRAME_END)
        |=> !r_state.receiving && r_state.tick_count == '0)
        else $error("frame end did not return to waiting mode");

    a_result_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_advance))
        else $error("result appeared without a sample");

endmodule

`default_nettype wire
